@@ hw/rtl/odp_pkg.sv @@
package odp_pkg;

  // Field widths
  localparam int unsigned DIVISOR_W = 12;
  localparam int unsigned REG_W     = 16;
  localparam int unsigned WORD_W    = 9;
  localparam int unsigned MUX_W     = 6;

  // Serial frame layout
  localparam int unsigned COMMAND_BITS = 8;
  localparam int unsigned DATA_BITS    = 9;
  localparam int unsigned MAX_BITS     = (COMMAND_BITS > DATA_BITS) ? COMMAND_BITS : DATA_BITS;
  localparam int unsigned BIT_CNT_W    = $clog2(MAX_BITS + 1);

  // Command codes sent ahead of each data word
  localparam logic [WORD_W-1:0] CMD_DIVISOR = WORD_W'(1);
  localparam logic [WORD_W-1:0] CMD_MUX     = WORD_W'(2);

  // Divisor limits and prescaler thresholds
  localparam logic [DIVISOR_W-1:0] DIV_MIN     = DIVISOR_W'(1);
  localparam logic [DIVISOR_W-1:0] DIV_MAX     = DIVISOR_W'(2052);
  localparam logic [DIVISOR_W-1:0] DIV_PRE4    = DIVISOR_W'(1026);
  localparam logic [DIVISOR_W-1:0] DIV_PRE2    = DIVISOR_W'(513);
  localparam logic [DIVISOR_W-1:0] DIV_SAT     = DIVISOR_W'(513);
  localparam logic [DIVISOR_W-1:0] DIV_OFFSET  = DIVISOR_W'(2);

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RST_TIME = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME = CFG_IDX_W'(4);

  localparam logic [REG_W-1:0] ONE_LOW_RST  = REG_W'(5);
  localparam logic [REG_W-1:0] ZERO_LOW_RST = REG_W'(112);
  localparam logic [REG_W-1:0] BIT_TIME_RST = REG_W'(150);
  localparam logic [REG_W-1:0] RST_TIME_RST = REG_W'(1200);
  localparam logic [REG_W-1:0] GAP_TIME_RST = REG_W'(240);

  // Words derived from one programming request
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] divisor_word;
    logic [MUX_W-1:0]  mux_word;
  } odp_words_t;

endpackage

@@ hw/rtl/odp_req_if.sv @@
interface odp_req_if;
  import odp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 tick;
  logic                 start_req;
  logic [DIVISOR_W-1:0] divisor;
  logic                 external_source;

  modport source (output valid, tick, start_req, divisor, external_source, input ready);
  modport sink   (input valid, tick, start_req, divisor, external_source, output ready);
endinterface

@@ hw/rtl/odp_res_if.sv @@
interface odp_res_if;
  logic valid;
  logic ready;
  logic osc_pin;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (output valid, osc_pin, busy_res, done_res, rejected, input ready);
  modport sink   (input valid, osc_pin, busy_res, done_res, rejected, output ready);
endinterface

@@ hw/rtl/odp_word_build.sv @@
module odp_word_build
  import odp_pkg::*;
(
  input  logic [DIVISOR_W-1:0] divisor_i,
  input  logic                 external_i,
  output odp_words_t           words_o
);

  logic [DIVISOR_W-1:0] scaled;
  logic [DIVISOR_W-1:0] sat;
  logic [DIVISOR_W-1:0] word_full;
  logic                 by2;
  logic                 off;

  always_comb begin
    scaled = divisor_i;
    by2    = 1'b0;
    off    = 1'b1;
    if (!external_i) begin
      if (divisor_i > DIV_PRE4) begin
        off    = 1'b0;
        scaled = divisor_i >> 2;
      end else if (divisor_i > DIV_PRE2) begin
        off    = 1'b0;
        by2    = 1'b1;
        scaled = divisor_i >> 1;
      end
    end
    sat       = (scaled > DIV_SAT) ? DIV_SAT : scaled;
    // divisor of 1 wraps to all ones in the low bits
    word_full = sat - DIV_OFFSET;

    words_o.valid        = divisor_i inside {[DIV_MIN:DIV_MAX]};
    words_o.divisor_word = word_full[WORD_W-1:0];
    words_o.mux_word     = {2'b11, by2, off, (divisor_i == DIV_MIN), external_i};
  end

endmodule

@@ hw/rtl/oscillator_divisor_programmer.sv @@
// An accepted request's result is written into the output register on the next clock edge.
// Throughput: one request per cycle; the output register is refilled in the
//   same cycle it is drained, so the input stalls only while a result waits.
// The sequence timing itself advances one step per request whose tick is set.
// Reset (rst_ni low, async): sequencer idle, pin high, counters and words cleared,
//   timing registers back to 5/112/150/1200/240 ticks, no result pending.
module oscillator_divisor_programmer
  import odp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  odp_req_if.sink              req_i,
  odp_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LO,
    PH_RST_HI,
    PH_CMD_LO,
    PH_CMD_HI,
    PH_DAT_LO,
    PH_DAT_HI,
    PH_GAP
  } phase_e;

  // Timing registers
  logic [REG_W-1:0] one_low_q, zero_low_q, bit_time_q, rst_time_q, gap_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_low_q  <= ONE_LOW_RST;
      zero_low_q <= ZERO_LOW_RST;
      bit_time_q <= BIT_TIME_RST;
      rst_time_q <= RST_TIME_RST;
      gap_time_q <= GAP_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ONE_LOW:  one_low_q  <= cfg_data_i;
        CFG_ZERO_LOW: zero_low_q <= cfg_data_i;
        CFG_BIT_TIME: bit_time_q <= cfg_data_i;
        CFG_RST_TIME: rst_time_q <= cfg_data_i;
        CFG_GAP_TIME: gap_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  phase_e               phase_q, phase_d;
  logic [REG_W-1:0]     tcnt_q, tcnt_d;
  logic [BIT_CNT_W-1:0] bcnt_q, bcnt_d;
  logic [WORD_W-1:0]    shift_q, shift_d;
  logic [WORD_W-1:0]    div_word_q, div_word_d;
  logic [MUX_W-1:0]     mux_word_q, mux_word_d;
  logic                 second_q, second_d;
  logic                 pin_q, pin_d;

  // Result register
  logic res_valid_q;
  logic res_pin_q, res_busy_q, res_done_q, res_rej_q;
  logic done, rej;

  // A request moves in whenever the output register is free or being drained.
  logic accept;
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  odp_words_t words;

  odp_word_build u_word_build (
    .divisor_i  (req_i.divisor),
    .external_i (req_i.external_source),
    .words_o    (words)
  );

  // Durations; a zero register counts as one tick.
  logic [REG_W-1:0] low_sel, low_len, bit_len, high_len, phase_len;
  logic [REG_W-1:0] tcnt_inc;
  logic [BIT_CNT_W:0] bcnt_inc;

  always_comb begin
    low_sel  = shift_q[0] ? one_low_q : zero_low_q;
    low_len  = (low_sel == '0) ? REG_W'(1) : low_sel;
    bit_len  = (bit_time_q == '0) ? REG_W'(1) : bit_time_q;
    // high part never shorter than one tick
    high_len = (bit_len > low_len) ? (bit_len - low_len) : REG_W'(1);
    case (phase_q)
      PH_RST_LO, PH_RST_HI: phase_len = (rst_time_q == '0) ? REG_W'(1) : rst_time_q;
      PH_CMD_LO, PH_DAT_LO: phase_len = low_len;
      PH_CMD_HI, PH_DAT_HI: phase_len = high_len;
      default:              phase_len = (gap_time_q == '0) ? REG_W'(1) : gap_time_q;
    endcase
  end

  assign tcnt_inc = tcnt_q + REG_W'(1);
  assign bcnt_inc = {1'b0, bcnt_q} + (BIT_CNT_W + 1)'(1);

  always_comb begin
    phase_d    = phase_q;
    tcnt_d     = tcnt_q;
    bcnt_d     = bcnt_q;
    shift_d    = shift_q;
    div_word_d = div_word_q;
    mux_word_d = mux_word_q;
    second_d   = second_q;
    pin_d      = pin_q;
    done       = 1'b0;
    rej        = 1'b0;

    if (accept) begin
      if (phase_q == PH_IDLE) begin
        // tick on the starting request is not counted
        if (req_i.start_req) begin
          if (!words.valid) begin
            rej = 1'b1;
          end else begin
            div_word_d = words.divisor_word;
            mux_word_d = words.mux_word;
            second_d   = 1'b0;
            bcnt_d     = '0;
            phase_d    = PH_RST_LO;
            tcnt_d     = '0;
            pin_d      = 1'b0;
          end
        end
      end else if (req_i.tick) begin
        tcnt_d = tcnt_inc;
        if (tcnt_inc >= phase_len) begin
          tcnt_d = '0;
          case (phase_q)
            PH_RST_LO: begin
              phase_d = PH_RST_HI;
              pin_d   = 1'b1;
            end
            PH_RST_HI: begin
              shift_d = second_q ? CMD_MUX : CMD_DIVISOR;
              bcnt_d  = '0;
              phase_d = PH_CMD_LO;
              pin_d   = 1'b0;
            end
            PH_CMD_LO: begin
              phase_d = PH_CMD_HI;
              pin_d   = 1'b1;
            end
            PH_DAT_LO: begin
              phase_d = PH_DAT_HI;
              pin_d   = 1'b1;
            end
            PH_CMD_HI: begin
              // next low pulse starts on this same tick
              pin_d = 1'b0;
              if (bcnt_inc >= (BIT_CNT_W + 1)'(COMMAND_BITS)) begin
                shift_d = second_q ? WORD_W'(mux_word_q) : div_word_q;
                bcnt_d  = '0;
                phase_d = PH_DAT_LO;
              end else begin
                shift_d = shift_q >> 1;
                bcnt_d  = bcnt_inc[BIT_CNT_W-1:0];
                phase_d = PH_CMD_LO;
              end
            end
            PH_DAT_HI: begin
              shift_d = shift_q >> 1;
              bcnt_d  = bcnt_inc[BIT_CNT_W-1:0];
              if (bcnt_inc >= (BIT_CNT_W + 1)'(DATA_BITS)) begin
                phase_d = PH_GAP;
                pin_d   = 1'b1;
              end else begin
                phase_d = PH_DAT_LO;
                pin_d   = 1'b0;
              end
            end
            default: begin
              if (!second_q) begin
                // mux word pass follows the divisor pass
                second_d = 1'b1;
                phase_d  = PH_RST_LO;
                pin_d    = 1'b0;
              end else begin
                phase_d  = PH_IDLE;
                pin_d    = 1'b1;
                second_d = 1'b0;
                bcnt_d   = '0;
                shift_d  = '0;
                done     = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tcnt_q      <= '0;
      bcnt_q      <= '0;
      shift_q     <= '0;
      div_word_q  <= '0;
      mux_word_q  <= '0;
      second_q    <= 1'b0;
      pin_q       <= 1'b1;
      res_valid_q <= 1'b0;
      res_pin_q   <= 1'b1;
      res_busy_q  <= 1'b0;
      res_done_q  <= 1'b0;
      res_rej_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tcnt_q     <= tcnt_d;
      bcnt_q     <= bcnt_d;
      shift_q    <= shift_d;
      div_word_q <= div_word_d;
      mux_word_q <= mux_word_d;
      second_q   <= second_d;
      pin_q      <= pin_d;
      if (accept) begin
        res_valid_q <= 1'b1;
        res_pin_q   <= pin_d;
        res_busy_q  <= (phase_d != PH_IDLE);
        res_done_q  <= done;
        res_rej_q   <= rej;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.osc_pin  = res_pin_q;
  assign res_o.busy_res = res_busy_q;
  assign res_o.done_res = res_done_q;
  assign res_o.rejected = res_rej_q;

endmodule

@@ dv/tb_oscillator_divisor_programmer.sv @@
`timescale 1ns / 100ps

module tb_oscillator_divisor_programmer;
  import odp_pkg::*;

  // Sequencer phases of the predictor, in the order a pass walks them
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RST_LO,
    SEQ_RST_HI,
    SEQ_CMD_LO,
    SEQ_CMD_HI,
    SEQ_DAT_LO,
    SEQ_DAT_HI,
    SEQ_GAP
  } seq_phase_e;

  // One request: a time step and/or a programming start
  typedef struct packed {
    logic                 tick;
    logic                 start_req;
    logic [DIVISOR_W-1:0] divisor;
    logic                 external_source;
  } tick_req_t;

  // Pin level and status seen after each request
  typedef struct packed {
    logic osc_pin;
    logic busy_res;
    logic done_res;
    logic rejected;
  } pin_status_t;

  // Sequencer state of the predictor
  typedef struct packed {
    seq_phase_e           phase;
    logic [REG_W-1:0]     ticks;
    logic [BIT_CNT_W-1:0] bits;
    logic [WORD_W-1:0]    shifter;
    logic [WORD_W-1:0]    div_word;
    logic [MUX_W-1:0]     mux_word;
    logic                 mux_pass;
    logic                 pin;
  } seq_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_data;

  odp_req_if req_if ();
  odp_res_if res_if ();

  oscillator_divisor_programmer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copies of the timing registers; they change only while the block is idle
  logic [REG_W-1:0] one_low_t    = ONE_LOW_RST;
  logic [REG_W-1:0] zero_low_t   = ZERO_LOW_RST;
  logic [REG_W-1:0] bit_time_t   = BIT_TIME_RST;
  logic [REG_W-1:0] reset_time_t = RST_TIME_RST;
  logic [REG_W-1:0] gap_time_t   = GAP_TIME_RST;

  tick_req_t   tick_req_q[$];    // requests waiting for the driver
  pin_status_t pin_status_q[$];  // predicted status, oldest first
  seq_state_t  seq_now;          // predictor state, advanced on accepted requests
  seq_state_t  seq_plan;         // look-ahead copy used to know when a program ends

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  fails        = 0;
  logic req_taken   = 1'b0;      // request accepted at the last rising edge
  logic steady      = 1'b0;      // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A zero duration counts as one tick
  function automatic int unsigned min_one(logic [REG_W-1:0] v);
    return (v == '0) ? 1 : v;
  endfunction

  // Low part of the bit now at the bottom of the shifter: one-low time for a one, zero-low time for a zero
  function automatic int unsigned low_ticks(seq_state_t st);
    return min_one(st.shifter[0] ? one_low_t : zero_low_t);
  endfunction

  function automatic int unsigned span_ticks(seq_state_t st);
    int unsigned lo;
    int unsigned bt;
    lo = low_ticks(st);
    bt = min_one(bit_time_t);
    case (st.phase)
      SEQ_RST_LO, SEQ_RST_HI: return min_one(reset_time_t);
      SEQ_CMD_LO, SEQ_DAT_LO: return lo;
      // high part fills the bit; if the bit time is too short it lasts one tick
      SEQ_CMD_HI, SEQ_DAT_HI: return (bt > lo) ? bt - lo : 1;
      default:                return min_one(gap_time_t);
    endcase
  endfunction

  // Advance the sequencer by one request and return the status after it
  function automatic pin_status_t program_step(inout seq_state_t st, input tick_req_t rq);
    pin_status_t          res;
    logic [DIVISOR_W-1:0] d;
    logic                 prescale_off;
    logic                 by_two;
    res = '0;
    if (st.phase == SEQ_IDLE) begin
      if (rq.start_req) begin
        if (rq.divisor < DIV_MIN || rq.divisor > DIV_MAX) begin
          res.rejected = 1'b1;
        end else begin
          d            = rq.divisor;
          prescale_off = 1'b1;
          by_two       = 1'b0;
          // prescaler only exists on the internal oscillator
          if (!rq.external_source) begin
            if (d > DIV_PRE4) begin
              prescale_off = 1'b0;
              d            = d >> 2;
            end else if (d > DIV_PRE2) begin
              prescale_off = 1'b0;
              by_two       = 1'b1;
              d            = d >> 1;
            end
          end
          if (d > DIV_SAT) d = DIV_SAT;
          // divisor of one wraps to all ones
          st.div_word = WORD_W'(d - DIV_OFFSET);
          st.mux_word = {2'b11, by_two, prescale_off, rq.divisor == DIV_MIN,
                         rq.external_source};
          st.mux_pass = 1'b0;
          st.bits     = '0;
          st.phase    = SEQ_RST_LO;
          st.ticks    = '0;
          st.pin      = 1'b0;
        end
      end
    end else if (rq.tick) begin
      // the tick on a start request is not counted, only ticks while busy
      st.ticks = st.ticks + 1'b1;
      if (st.ticks >= span_ticks(st)) begin
        st.ticks = '0;
        case (st.phase)
          SEQ_RST_LO: begin
            st.phase = SEQ_RST_HI;
            st.pin   = 1'b1;
          end
          SEQ_RST_HI: begin
            st.shifter = st.mux_pass ? CMD_MUX : CMD_DIVISOR;
            st.bits    = '0;
            st.phase   = SEQ_CMD_LO;
            st.pin     = 1'b0;
          end
          SEQ_CMD_LO: begin
            st.phase = SEQ_CMD_HI;
            st.pin   = 1'b1;
          end
          SEQ_DAT_LO: begin
            st.phase = SEQ_DAT_HI;
            st.pin   = 1'b1;
          end
          SEQ_CMD_HI: begin
            // next low pulse starts on the same tick the bit ends
            st.shifter = st.shifter >> 1;
            st.bits    = st.bits + 1'b1;
            st.pin     = 1'b0;
            if (st.bits >= COMMAND_BITS) begin
              st.shifter = st.mux_pass ? WORD_W'(st.mux_word) : st.div_word;
              st.bits    = '0;
              st.phase   = SEQ_DAT_LO;
            end else begin
              st.phase = SEQ_CMD_LO;
            end
          end
          SEQ_DAT_HI: begin
            st.shifter = st.shifter >> 1;
            st.bits    = st.bits + 1'b1;
            if (st.bits >= DATA_BITS) begin
              st.phase = SEQ_GAP;
              st.pin   = 1'b1;
            end else begin
              st.phase = SEQ_DAT_LO;
              st.pin   = 1'b0;
            end
          end
          default: begin
            if (!st.mux_pass) begin
              // second pass carries the mux word
              st.mux_pass = 1'b1;
              st.phase    = SEQ_RST_LO;
              st.pin      = 1'b0;
            end else begin
              st.phase    = SEQ_IDLE;
              st.pin      = 1'b1;
              st.mux_pass = 1'b0;
              st.bits     = '0;
              st.shifter  = '0;
              res.done_res = 1'b1;
            end
          end
        endcase
      end
    end
    res.osc_pin  = st.pin;
    res.busy_res = (st.phase != SEQ_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, holds each until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    tick_req_t nxt;
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (tick_req_q.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
          nxt = tick_req_q.pop_front();
          req_if.valid           <= 1'b1;
          req_if.tick            <= nxt.tick;
          req_if.start_req       <= nxt.start_req;
          req_if.divisor         <= nxt.divisor;
          req_if.external_source <= nxt.external_source;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs so the block backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : receive
    int hold_left;
    bit long_hold_done;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else if ((!long_hold_done && tick_req_q.size() > 40) ||
                   (!steady && $urandom_range(0, 4999) == 0)) begin
        // hold off while plenty of requests are still being offered
        long_hold_done = 1'b1;
        hold_left      = $urandom_range(150, 300);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || $urandom_range(0, 99) >= 9;
      end
    end else begin
      hold_left      = 0;
      long_hold_done = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on accepted requests, checks accepted results
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, got %0b", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    pin_status_t want;
    tick_req_t   rq;
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      // compare first: a result never belongs to a request taken on the same edge
      if (res_if.valid && res_if.ready) begin
        if (pin_status_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = pin_status_q.pop_front();
          check_field("osc_pin", want.osc_pin, res_if.osc_pin);
          check_field("busy_res", want.busy_res, res_if.busy_res);
          check_field("done_res", want.done_res, res_if.done_res);
          check_field("rejected", want.rejected, res_if.rejected);
        end
      end
      if (req_if.valid && req_if.ready) begin
        rq.tick            = req_if.tick;
        rq.start_req       = req_if.start_req;
        rq.divisor         = req_if.divisor;
        rq.external_source = req_if.external_source;
        pin_status_q.push_back(program_step(seq_now, rq));
        accepted_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic tick, logic start, logic [DIVISOR_W-1:0] div, logic ext);
    tick_req_t rq;
    rq.tick            = tick;
    rq.start_req       = start;
    rq.divisor         = div;
    rq.external_source = ext;
    tick_req_q.push_back(rq);
    void'(program_step(seq_plan, rq));
    queued_cnt++;
  endtask

  // One start request, then time steps until both passes are out.
  // Starts thrown in while busy must be ignored.
  task automatic run_program(logic [DIVISOR_W-1:0] div, logic ext, int tick_pct);
    push_req(1'($urandom_range(0, 1)), 1'b1, div, ext);
    while (seq_plan.phase != SEQ_IDLE) begin
      if ($urandom_range(0, 24) == 0)
        push_req($urandom_range(0, 99) < tick_pct, 1'b1, DIVISOR_W'($urandom),
                 1'($urandom_range(0, 1)));
      else
        push_req($urandom_range(0, 99) < tick_pct, 1'b0, DIVISOR_W'($urandom),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Edges of the prescaler bands weigh heavily; the rest is spread over 1..2052
  function automatic logic [DIVISOR_W-1:0] pick_divisor();
    case ($urandom_range(0, 9))
      0:       return DIV_MIN;
      1:       return DIV_MAX;
      2:       return DIVISOR_W'(DIV_PRE2 + $urandom_range(0, 1));
      3:       return DIVISOR_W'(DIV_PRE4 + $urandom_range(0, 1));
      4:       return DIVISOR_W'($urandom_range(2, 20));
      default: return DIVISOR_W'($urandom_range(DIV_MIN, DIV_MAX));
    endcase
  endfunction

  // Wait until every request is taken and every result checked
  task automatic settle();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || pin_status_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ONE_LOW:  one_low_t    = val;
      CFG_ZERO_LOW: zero_low_t   = val;
      CFG_BIT_TIME: bit_time_t   = val;
      CFG_RST_TIME: reset_time_t = val;
      CFG_GAP_TIME: gap_time_t   = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [REG_W-1:0] one_lo, logic [REG_W-1:0] zero_lo,
                            logic [REG_W-1:0] bit_t, logic [REG_W-1:0] rst_t,
                            logic [REG_W-1:0] gap_t);
    settle();
    cfg_write(CFG_ONE_LOW, one_lo);
    cfg_write(CFG_ZERO_LOW, zero_lo);
    cfg_write(CFG_BIT_TIME, bit_t);
    cfg_write(CFG_RST_TIME, rst_t);
    cfg_write(CFG_GAP_TIME, gap_t);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly whole programs with random content; the rest rejected starts and idle noise
  task automatic random_phase(int n_reqs);
    int first;
    first = queued_cnt;
    while (queued_cnt - first < n_reqs) begin
      case ($urandom_range(0, 9))
        0: push_req(1'($urandom_range(0, 1)), 1'b1,
                    DIVISOR_W'($urandom_range(0, 1) ? 0 :
                               $urandom_range(DIV_MAX + 1, {DIVISOR_W{1'b1}})),
                    1'($urandom_range(0, 1)));
        1: repeat ($urandom_range(1, 5))
             push_req(1'($urandom_range(0, 1)), 1'b0, DIVISOR_W'($urandom),
                      1'($urandom_range(0, 1)));
        default: run_program(pick_divisor(), 1'($urandom_range(0, 1)), 70);
      endcase
    end
  endtask

  initial begin
    // every input known from time zero
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.tick            = 1'b0;
    req_if.start_req       = 1'b0;
    req_if.divisor         = '0;
    req_if.external_source = 1'b0;
    res_if.ready           = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_ONE_LOW;
    cfg_data               = '0;
    seq_now                = '0;
    seq_now.pin            = 1'b1;
    seq_plan               = seq_now;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset timing: rejected divisors at both ends of the field, an idle tick
    push_req(1'b0, 1'b1, '0, 1'b0);
    push_req(1'b1, 1'b1, DIVISOR_W'(DIV_MAX + 1), 1'b1);
    push_req(1'b1, 1'b1, {DIVISOR_W{1'b1}}, 1'b0);
    push_req(1'b1, 1'b0, 12'hAAA, 1'b1);

    // All registers zero: each duration collapses to one tick; every prescaler band
    set_timing('0, '0, '0, '0, '0);
    run_program(DIV_MIN, 1'b0, 100);
    run_program(DIVISOR_W'(DIV_PRE2 + 1), 1'b0, 100);
    run_program(DIVISOR_W'(DIV_PRE4 + 1), 1'b0, 100);
    run_program(DIV_MAX, 1'b1, 100);
    push_req(1'b0, 1'b1, DIVISOR_W'(DIV_MAX + 1), 1'b0);

    // Bit time not above either low time: high part is a single tick
    set_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
    run_program(DIV_OFFSET, 1'b1, 80);

    // Random programs under a few short timings; one stretch without idling
    for (int r = 0; r < 3; r++) begin
      set_timing(REG_W'($urandom_range(0, 3)), REG_W'($urandom_range(0, 3)),
                 REG_W'($urandom_range(0, 6)), REG_W'($urandom_range(0, 3)),
                 REG_W'($urandom_range(0, 3)));
      steady = (r == 1);
      random_phase(120);
      settle();
      steady = 1'b0;
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
